@@ hw/rtl/crast_pkg.sv @@
// Shared constants, types and the coordinate wrap function of the circle rasterizer.
package crast_pkg;

    // Coordinate arithmetic width; results wrap to this many bits two's complement.
    localparam int COORD_WIDTH = 16;
    // Width of the span coordinate ports.
    localparam int OUT_WIDTH   = 16;
    // Full-precision width of a center plus or minus an offset.
    localparam int SUM_WIDTH   = 17;
    // Number of low bits of a sum that survive the wrap.
    localparam int WRAP_WIDTH  = (COORD_WIDTH < SUM_WIDTH) ? COORD_WIDTH : SUM_WIDTH;

    // Command codes of an input request.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Index of the last span of one step in each mode.
    localparam logic [2:0] FILL_LAST_IDX    = 3'd3;
    localparam logic [2:0] OUTLINE_LAST_IDX = 3'd7;

    typedef logic signed [SUM_WIDTH-1:0] sum_t;
    typedef logic signed [OUT_WIDTH-1:0] coord_t;

    // Wrap a full-precision sum to the coordinate width and sign-extend to the port width.
    function automatic coord_t coord_wrap(input sum_t v);
        coord_t r;
        for (int i = 0; i < OUT_WIDTH; i++) begin
            r[i] = (i < WRAP_WIDTH) ? v[i] : v[WRAP_WIDTH-1];
        end
        return r;
    endfunction

endpackage

@@ hw/rtl/circle_rasterizer_core.sv @@
// Circle rasterizer core: iteration state, span sequencer and result register.
//
// Usage: the input channel (s_*) takes requests of two kinds. A start request
// (s_cmd = 0) latches center, radius and fill mode and gives no result. A step
// request (s_cmd = 1) runs one iteration of the circle loop and gives eight
// single-pixel points in outline mode or four horizontal spans in fill mode on
// the result channel (m_*), one per cycle while the receiver takes them;
// m_last_of_step marks the last one and m_finished marks the last one of the
// circle's final iteration. A step while no circle is in progress gives
// nothing. The first result of a step passes through the sequencer's busy
// register and then the result register. A step that produces results
// occupies the span sequencer, one span a cycle while the receiver is ready,
// and the next request is taken in the cycle the last span moves into the
// result register. Start requests and idle steps do not occupy the sequencer.
// The result register parts the two sides: while the receiver stalls, the
// current span holds and the sequencer waits behind it; s_ready then stays low
// only while the sequencer still owes spans.
// Reset (aresetn low, synchronous) clears the circle state, the sequencer and
// the result valid flag: no circle in progress and no result pending.
module circle_rasterizer_core
    import crast_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_cmd,
    input  logic signed [14:0]          s_center_x,
    input  logic signed [14:0]          s_center_y,
    input  logic        [13:0]          s_radius,
    input  logic                        s_fill_mode,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [OUT_WIDTH-1:0] m_x_start,
    output logic signed [OUT_WIDTH-1:0] m_x_end,
    output logic signed [OUT_WIDTH-1:0] m_row,
    output logic                        m_last_of_step,
    output logic                        m_finished
);

    // Circle state.
    logic signed [14:0] offset_x_reg;
    logic signed [14:0] offset_y_reg;
    logic signed [16:0] decision_reg;
    logic signed [14:0] center_x_reg;
    logic signed [14:0] center_y_reg;
    logic        [13:0] radius_reg;
    logic               fill_reg;
    logic               active_reg;

    // Span sequencer: snapshot of one step and the index of the next span.
    logic               emit_busy_reg;
    logic        [2:0]  emit_idx_reg;
    logic signed [14:0] snap_cx_reg;
    logic signed [14:0] snap_cy_reg;
    logic signed [14:0] snap_x_reg;
    logic signed [14:0] snap_y_reg;
    logic               snap_fill_reg;
    logic               snap_fin_reg;

    // Result register.
    logic               m_valid_reg;
    coord_t             x_start_reg;
    coord_t             x_end_reg;
    coord_t             row_reg;
    logic               last_reg;
    logic               fin_reg;

    logic               s_accept;
    logic               step_emits;
    logic               step_stops;
    logic               out_load;
    logic               emit_adv;
    logic               emit_last;

    logic signed [17:0] d_ext;
    logic signed [17:0] x_ext;
    logic signed [17:0] y_ext;
    logic signed [17:0] r_ext;
    logic signed [17:0] d_sum;
    logic signed [16:0] decision_next;
    logic signed [14:0] offset_x_next;
    logic signed [14:0] offset_y_next;
    logic               fin_next;

    sum_t               cx_ext;
    sum_t               cy_ext;
    sum_t               sx_ext;
    sum_t               sy_ext;
    sum_t               cx_px;
    sum_t               cx_mx;
    sum_t               cx_py;
    sum_t               cx_my;
    sum_t               cy_px;
    sum_t               cy_mx;
    sum_t               cy_py;
    sum_t               cy_my;
    sum_t               span_xs;
    sum_t               span_xe;
    sum_t               span_row;

    // Handshake and sequencer control.
    assign out_load   = !m_valid_reg || m_ready;
    assign emit_adv   = emit_busy_reg && out_load;
    assign emit_last  = (emit_idx_reg == (snap_fill_reg ? FILL_LAST_IDX : OUTLINE_LAST_IDX));
    assign s_ready    = !emit_busy_reg || (emit_adv && emit_last);
    assign s_accept   = s_valid && s_ready;
    assign step_emits = (s_cmd == CMD_STEP) && active_reg && (offset_y_reg >= offset_x_reg);
    assign step_stops = (s_cmd == CMD_STEP) && active_reg && (offset_y_reg < offset_x_reg);

    // Three-case update of the decision variable and offsets.
    always_comb begin
        d_ext = {decision_reg[16], decision_reg};
        x_ext = {{3{offset_x_reg[14]}}, offset_x_reg};
        y_ext = {{3{offset_y_reg[14]}}, offset_y_reg};
        r_ext = {4'b0000, radius_reg};
        if (d_ext >= (x_ext + x_ext)) begin
            d_sum         = d_ext - (x_ext + x_ext) - 18'sd1;
            offset_x_next = offset_x_reg + 15'sd1;
            offset_y_next = offset_y_reg;
        end else if (d_ext < ((r_ext - y_ext) + (r_ext - y_ext))) begin
            d_sum         = d_ext + (y_ext + y_ext) - 18'sd1;
            offset_x_next = offset_x_reg;
            offset_y_next = offset_y_reg - 15'sd1;
        end else begin
            d_sum         = d_ext + ((y_ext - x_ext - 18'sd1) + (y_ext - x_ext - 18'sd1));
            offset_x_next = offset_x_reg + 15'sd1;
            offset_y_next = offset_y_reg - 15'sd1;
        end
        decision_next = d_sum[16:0];
        fin_next      = (offset_y_next < offset_x_next);
    end

    // Circle state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_x_reg <= '0;
            offset_y_reg <= '0;
            decision_reg <= '0;
            center_x_reg <= '0;
            center_y_reg <= '0;
            radius_reg   <= '0;
            fill_reg     <= 1'b0;
            active_reg   <= 1'b0;
        end else if (s_accept) begin
            if (s_cmd == CMD_START) begin
                center_x_reg <= s_center_x;
                center_y_reg <= s_center_y;
                radius_reg   <= s_radius;
                fill_reg     <= s_fill_mode;
                offset_x_reg <= '0;
                offset_y_reg <= {1'b0, s_radius};
                decision_reg <= {3'b000, s_radius} - 17'sd1;
                active_reg   <= 1'b1;
            end else if (step_emits) begin
                offset_x_reg <= offset_x_next;
                offset_y_reg <= offset_y_next;
                decision_reg <= decision_next;
                if (fin_next) begin
                    active_reg <= 1'b0;
                end
            end else if (step_stops) begin
                active_reg <= 1'b0;
            end
        end
    end

    // Sequencer control: load a snapshot on a step, walk the span index.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_busy_reg <= 1'b0;
            emit_idx_reg  <= '0;
        end else if (s_accept && step_emits) begin
            emit_busy_reg <= 1'b1;
            emit_idx_reg  <= '0;
        end else if (emit_adv) begin
            if (emit_last) begin
                emit_busy_reg <= 1'b0;
            end else begin
                emit_idx_reg <= emit_idx_reg + 3'd1;
            end
        end
    end

    // Snapshot payload of the step being emitted.
    always_ff @(posedge aclk) begin
        if (s_accept && step_emits) begin
            snap_cx_reg   <= center_x_reg;
            snap_cy_reg   <= center_y_reg;
            snap_x_reg    <= offset_x_reg;
            snap_y_reg    <= offset_y_reg;
            snap_fill_reg <= fill_reg;
            snap_fin_reg  <= fin_next;
        end
    end

    // Center plus and minus each offset at full precision.
    always_comb begin
        cx_ext = {{2{snap_cx_reg[14]}}, snap_cx_reg};
        cy_ext = {{2{snap_cy_reg[14]}}, snap_cy_reg};
        sx_ext = {{2{snap_x_reg[14]}}, snap_x_reg};
        sy_ext = {{2{snap_y_reg[14]}}, snap_y_reg};
        cx_px  = cx_ext + sx_ext;
        cx_mx  = cx_ext - sx_ext;
        cx_py  = cx_ext + sy_ext;
        cx_my  = cx_ext - sy_ext;
        cy_px  = cy_ext + sx_ext;
        cy_mx  = cy_ext - sx_ext;
        cy_py  = cy_ext + sy_ext;
        cy_my  = cy_ext - sy_ext;
    end

    // Select the span for the current index.
    always_comb begin
        span_xs  = cx_px;
        span_xe  = cx_px;
        span_row = cy_py;
        if (snap_fill_reg) begin
            case (emit_idx_reg[1:0])
                2'd0: begin
                    span_xs  = cx_my;
                    span_xe  = cx_py;
                    span_row = cy_px;
                end
                2'd1: begin
                    span_xs  = cx_mx;
                    span_xe  = cx_px;
                    span_row = cy_py;
                end
                2'd2: begin
                    span_xs  = cx_mx;
                    span_xe  = cx_px;
                    span_row = cy_my;
                end
                default: begin
                    span_xs  = cx_my;
                    span_xe  = cx_py;
                    span_row = cy_mx;
                end
            endcase
        end else begin
            case (emit_idx_reg)
                3'd0: begin
                    span_xs  = cx_px;
                    span_row = cy_py;
                end
                3'd1: begin
                    span_xs  = cx_py;
                    span_row = cy_px;
                end
                3'd2: begin
                    span_xs  = cx_mx;
                    span_row = cy_py;
                end
                3'd3: begin
                    span_xs  = cx_my;
                    span_row = cy_px;
                end
                3'd4: begin
                    span_xs  = cx_px;
                    span_row = cy_my;
                end
                3'd5: begin
                    span_xs  = cx_py;
                    span_row = cy_mx;
                end
                3'd6: begin
                    span_xs  = cx_mx;
                    span_row = cy_my;
                end
                default: begin
                    span_xs  = cx_my;
                    span_row = cy_mx;
                end
            endcase
            span_xe = span_xs;
        end
    end

    // Result register valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= emit_busy_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge aclk) begin
        if (emit_adv) begin
            x_start_reg <= coord_wrap(span_xs);
            x_end_reg   <= coord_wrap(span_xe);
            row_reg     <= coord_wrap(span_row);
            last_reg    <= emit_last;
            fin_reg     <= emit_last && snap_fin_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_x_start      = x_start_reg;
    assign m_x_end        = x_end_reg;
    assign m_row          = row_reg;
    assign m_last_of_step = last_reg;
    assign m_finished     = fin_reg;

endmodule
